FILE: sv/mesr_pkg.sv
// shared constants and types for the midi sysex reassembler
`default_nettype none

package mesr_pkg;

    typedef logic [7:0] byte_t;
    typedef logic [1:0] kind_t;

    // midi byte codes
    localparam byte_t RT_MASK  = 8'hF8;
    localparam byte_t SX_START = 8'hF0;
    localparam byte_t SX_END   = 8'hF7;
    localparam byte_t DATA_MAX = 8'h7F;

    // result kinds
    localparam kind_t KIND_SHORT = 2'd0;
    localparam kind_t KIND_RT    = 2'd1;
    localparam kind_t KIND_SYSEX = 2'd2;

    function automatic logic is_realtime(input byte_t b);
        is_realtime = ((b & RT_MASK) == RT_MASK);
    endfunction

endpackage

`default_nettype wire

FILE: sv/mesr_store.sv
// sysex byte store, one write port and one registered read port
`default_nettype none

module mesr_store #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire mesr_pkg::byte_t   wr_data,
    input  wire logic              rd_en,
    input  wire logic [AW-1:0]     rd_addr,
    output mesr_pkg::byte_t        rd_data
);

    mesr_pkg::byte_t mem [DEPTH];
    mesr_pkg::byte_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: sv/midi_event_sysex_reassembler_unit.sv
// top level of the midi event sysex reassembler
// short and realtime beats are decoded in the status state and registered at the output
// one input word at a time: the next is accepted only back in the idle state
// sysex words: a status state, then a byte state per byte up to f7 or the word's end
// an f7 run then reads each stored byte and loads it into the output register
// reset: control state and output valid clear; payload registers and store not reset
`default_nettype none

module midi_event_sysex_reassembler_unit #(
    parameter int BUFFER_DEPTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input beat
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // event_word
    // output beat
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // status_byte, data_one, data_two, sysex_byte
    output logic             m_axis_tlast,   // sysex_last
    output logic [2:0]       m_axis_tuser    // kind (2), sysex_truncated
);

    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int AW = $clog2(BUFFER_DEPTH);

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_STATUS = 3'd1;
    localparam logic [2:0] ST_BYTE   = 3'd2;
    localparam logic [2:0] ST_READ   = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    logic [2:0]  state_reg,    state_next;
    logic [31:0] word_reg,     word_next;
    logic [1:0]  pos_reg,      pos_next;
    logic        in_sysex_reg, in_sysex_next;
    logic [CW-1:0] count_reg,  count_next;
    logic        ovf_reg,      ovf_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic [CW-1:0] rd_idx_inc;

    // output register, parts the sequencer from the downstream stall
    logic              out_valid_reg, out_valid_next;
    mesr_pkg::kind_t   out_kind_reg;
    mesr_pkg::byte_t   out_status_reg, out_d1_reg, out_d2_reg, out_sx_reg;
    logic              out_last_reg, out_trunc_reg;
    logic              out_free;

    // beat to load this cycle
    logic              emit;
    mesr_pkg::kind_t   emit_kind;
    mesr_pkg::byte_t   emit_status, emit_d1, emit_d2, emit_sx;
    logic              emit_last, emit_trunc;

    mesr_pkg::byte_t   st_byte, cur_byte, rd_data;
    logic              restart, run_active, run_last;
    logic              wr_en, rd_en;

    assign st_byte    = word_reg[7:0];
    assign cur_byte   = word_reg[{pos_reg, 3'b000} +: 8];
    assign out_free   = !out_valid_reg || m_axis_tready;
    assign rd_idx_inc = rd_idx_reg + CW'(1);
    assign run_last   = (rd_idx_inc == count_reg);

    // a non-realtime status other than f7 aborts a partial message
    assign restart    = in_sysex_reg && (st_byte > mesr_pkg::DATA_MAX)
                        && (st_byte < mesr_pkg::SX_END);
    assign run_active = in_sysex_reg && !restart;

    // writes happen only in the byte state and reads only in the read state,
    // so the two ports never touch the store in the same cycle
    mesr_store #(
        .DEPTH (BUFFER_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (cur_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next    = state_reg;
        word_next     = word_reg;
        pos_next      = pos_reg;
        in_sysex_next = in_sysex_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        rd_idx_next   = rd_idx_reg;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        emit          = 1'b0;
        emit_kind     = mesr_pkg::KIND_SHORT;
        emit_status   = '0;
        emit_d1       = '0;
        emit_d2       = '0;
        emit_sx       = '0;
        emit_last     = 1'b0;
        emit_trunc    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    word_next  = s_axis_tdata;
                    state_next = ST_STATUS;
                end
            end

            ST_STATUS:
            begin
                if (out_free)
                begin
                    pos_next = 2'd0;
                    if (run_active)
                    begin
                        state_next = ST_BYTE;
                    end
                    else
                    begin
                        // outside sysex, or the partial run just dropped
                        in_sysex_next = 1'b0;
                        count_next    = '0;
                        ovf_next      = 1'b0;
                        if (mesr_pkg::is_realtime(st_byte))
                        begin
                            emit        = 1'b1;
                            emit_kind   = mesr_pkg::KIND_RT;
                            emit_status = st_byte;
                            state_next  = ST_IDLE;
                        end
                        else if (st_byte != mesr_pkg::SX_START)
                        begin
                            emit        = 1'b1;
                            emit_kind   = mesr_pkg::KIND_SHORT;
                            emit_status = st_byte;
                            emit_d1     = word_reg[15:8];
                            emit_d2     = word_reg[23:16];
                            state_next  = ST_IDLE;
                        end
                        else
                        begin
                            in_sysex_next = 1'b1;
                            state_next    = ST_BYTE;
                        end
                    end
                end
            end

            ST_BYTE:
            begin
                if (out_free)
                begin
                    if (mesr_pkg::is_realtime(cur_byte))
                    begin
                        // embedded realtime goes straight out, not stored
                        emit        = 1'b1;
                        emit_kind   = mesr_pkg::KIND_RT;
                        emit_status = cur_byte;
                    end
                    else
                    begin
                        if (count_reg < CW'(BUFFER_DEPTH))
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end

                    if (!mesr_pkg::is_realtime(cur_byte) && (cur_byte == mesr_pkg::SX_END))
                    begin
                        // end of message, rest of the word is ignored
                        rd_idx_next = '0;
                        state_next  = ST_READ;
                    end
                    else if (pos_reg == 2'd3)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pos_next = pos_reg + 2'd1;
                    end
                end
            end

            ST_READ:
            begin
                rd_en      = 1'b1;
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_kind  = mesr_pkg::KIND_SYSEX;
                    emit_sx    = rd_data;
                    emit_last  = run_last;
                    emit_trunc = ovf_reg;
                    if (run_last)
                    begin
                        in_sysex_next = 1'b0;
                        count_next    = '0;
                        ovf_next      = 1'b0;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_inc;
                        state_next  = ST_READ;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = emit ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            in_sysex_reg  <= 1'b0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            in_sysex_reg  <= in_sysex_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        if (emit)
        begin
            out_kind_reg   <= emit_kind;
            out_status_reg <= emit_status;
            out_d1_reg     <= emit_d1;
            out_d2_reg     <= emit_d2;
            out_sx_reg     <= emit_sx;
            out_last_reg   <= emit_last;
            out_trunc_reg  <= emit_trunc;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_sx_reg, out_d2_reg, out_d1_reg, out_status_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = {out_trunc_reg, out_kind_reg};

endmodule

`default_nettype wire

FILE: sv/mesr_checker.sv
// port-level checks for the midi sysex reassembler, bound to the top level
`default_nettype none

module mesr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic        m_axis_tlast,
    input wire logic [2:0]  m_axis_tuser
);

    // one word in flight: no second beat right after an accepted one
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted on consecutive cycles");

    // realtime beats carry a realtime status and nothing else
    a_rt_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser[1:0] == mesr_pkg::KIND_RT))
        |-> (((m_axis_tdata[7:0] & mesr_pkg::RT_MASK) == mesr_pkg::RT_MASK)
             && (m_axis_tdata[31:8] == 24'd0)))
        else $error("malformed realtime beat");

    // last and truncated marks only on sysex bytes
    a_sysex_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tlast || m_axis_tuser[2]))
        |-> (m_axis_tuser[1:0] == mesr_pkg::KIND_SYSEX))
        else $error("sysex mark on a non-sysex beat");

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready)
        |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
             && $stable(m_axis_tlast)))
        else $error("output beat changed while stalled");

endmodule

bind midi_event_sysex_reassembler_unit mesr_checker u_mesr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
